>>> design/shcv_pkg.sv
package shcv_pkg;

	typedef logic [31:0] word_t;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam int unsigned IV_WORDS = 8;
	localparam logic [5:0] LEN_FIELD_START = 6'd60;
	localparam logic [5:0] LONG_TAIL_FILL = 6'd56;
	localparam logic [5:0] BLOCK_LAST_BYTE = 6'd63;
	localparam logic [5:0] ROUND_LAST = 6'd63;

	// round phases: four schedule reads, word build, sums, state update
	localparam logic [2:0] PH_RD16 = 3'd0;
	localparam logic [2:0] PH_RD15 = 3'd1;
	localparam logic [2:0] PH_RD7 = 3'd2;
	localparam logic [2:0] PH_RD2 = 3'd3;
	localparam logic [2:0] PH_WORD = 3'd4;
	localparam logic [2:0] PH_SUM = 3'd5;
	localparam logic [2:0] PH_UPD = 3'd6;

	typedef enum logic [1:0] {
		TS_IDLE,
		TS_PAD,
		TS_CMP,
		TS_OUT
	} top_state_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_ROUND,
		CS_FINAL
	} cmp_state_t;

	// one packed word going into the block memory
	typedef struct packed {
		logic       we;
		logic [3:0] addr;
		word_t      data;
	} put_t;

	// control from the byte sequencer to the compression unit
	typedef struct packed {
		logic start;
		logic load_iv;
	} cmp_ctl_t;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_sig0(input word_t x);
		big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sig1(input word_t x);
		big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t sml_sig0(input word_t x);
		sml_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t sml_sig1(input word_t x);
		sml_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t round_k(input logic [5:0] r);
		unique case (r)
			6'd0: round_k = 32'h428a2f98;  6'd1: round_k = 32'h71374491;
			6'd2: round_k = 32'hb5c0fbcf;  6'd3: round_k = 32'he9b5dba5;
			6'd4: round_k = 32'h3956c25b;  6'd5: round_k = 32'h59f111f1;
			6'd6: round_k = 32'h923f82a4;  6'd7: round_k = 32'hab1c5ed5;
			6'd8: round_k = 32'hd807aa98;  6'd9: round_k = 32'h12835b01;
			6'd10: round_k = 32'h243185be; 6'd11: round_k = 32'h550c7dc3;
			6'd12: round_k = 32'h72be5d74; 6'd13: round_k = 32'h80deb1fe;
			6'd14: round_k = 32'h9bdc06a7; 6'd15: round_k = 32'hc19bf174;
			6'd16: round_k = 32'he49b69c1; 6'd17: round_k = 32'hefbe4786;
			6'd18: round_k = 32'h0fc19dc6; 6'd19: round_k = 32'h240ca1cc;
			6'd20: round_k = 32'h2de92c6f; 6'd21: round_k = 32'h4a7484aa;
			6'd22: round_k = 32'h5cb0a9dc; 6'd23: round_k = 32'h76f988da;
			6'd24: round_k = 32'h983e5152; 6'd25: round_k = 32'ha831c66d;
			6'd26: round_k = 32'hb00327c8; 6'd27: round_k = 32'hbf597fc7;
			6'd28: round_k = 32'hc6e00bf3; 6'd29: round_k = 32'hd5a79147;
			6'd30: round_k = 32'h06ca6351; 6'd31: round_k = 32'h14292967;
			6'd32: round_k = 32'h27b70a85; 6'd33: round_k = 32'h2e1b2138;
			6'd34: round_k = 32'h4d2c6dfc; 6'd35: round_k = 32'h53380d13;
			6'd36: round_k = 32'h650a7354; 6'd37: round_k = 32'h766a0abb;
			6'd38: round_k = 32'h81c2c92e; 6'd39: round_k = 32'h92722c85;
			6'd40: round_k = 32'ha2bfe8a1; 6'd41: round_k = 32'ha81a664b;
			6'd42: round_k = 32'hc24b8b70; 6'd43: round_k = 32'hc76c51a3;
			6'd44: round_k = 32'hd192e819; 6'd45: round_k = 32'hd6990624;
			6'd46: round_k = 32'hf40e3585; 6'd47: round_k = 32'h106aa070;
			6'd48: round_k = 32'h19a4c116; 6'd49: round_k = 32'h1e376c08;
			6'd50: round_k = 32'h2748774c; 6'd51: round_k = 32'h34b0bcb5;
			6'd52: round_k = 32'h391c0cb3; 6'd53: round_k = 32'h4ed8aa4a;
			6'd54: round_k = 32'h5b9cca4f; 6'd55: round_k = 32'h682e6ff3;
			6'd56: round_k = 32'h748f82ee; 6'd57: round_k = 32'h78a5636f;
			6'd58: round_k = 32'h84c87814; 6'd59: round_k = 32'h8cc70208;
			6'd60: round_k = 32'h90befffa; 6'd61: round_k = 32'ha4506ceb;
			6'd62: round_k = 32'hbef9a3f7; 6'd63: round_k = 32'hc67178f2;
		endcase
	endfunction

endpackage

>>> design/sha256_hash_custom_iv_unit.sv
// SHA-256 engine with a programmable initial hash value.
// Input channel (in_valid/in_ready): one transaction carries kind and data_byte.
// kind 0 appends a byte; kind 1 finishes the message. The first transaction
// after reset or after a finish latches iv_word0..7 as the chaining value.
// Output channel (out_valid/out_ready): eight digest words, word 0 first,
// last_word marks the eighth.
// Config port: cfg_we/cfg_index/cfg_wdata writes iv_word[cfg_index];
// indexes 8 and above are ignored. Write only while the block is idle.
// Throughput: one data byte per cycle, except that the byte that fills a block
// holds off input until its compression (64 rounds, one final addition) is done.
// The round rate is set by the single-read-port schedule memory: four window
// reads per round. A finish pads one byte a cycle up to the block end, runs
// one or two compressions (two when 56 or more bytes wait), then presents the
// eight words, one per cycle while out_ready stays high. Input is not taken
// while digest words are pending; a stalled receiver simply holds the output.
// Reset clears all control state and the iv registers to zero.
module sha256_hash_custom_iv_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                kind,
	input  logic [7:0]          data_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [31:0]         digest_word,
	output logic                last_word,
	input  logic                cfg_we,
	input  logic [3:0]          cfg_index,
	input  logic [31:0]         cfg_wdata
);
	import shcv_pkg::*;

	top_state_t state_q, state_d;
	word_t iv_q [8];
	logic [5:0] fill_q, fill_eff;
	logic [28:0] total_q, total_eff;
	logic open_q, fin_q, extra_q;
	word_t bits_q;
	logic [23:0] wa_q;
	logic [2:0] idx_q;
	logic in_acc, out_acc;
	logic put_en;
	logic [7:0] put_byte, len_byte;
	put_t put;
	cmp_ctl_t ctl;
	logic done;

	assign in_ready = (state_q == TS_IDLE);
	assign in_acc = in_valid && in_ready;
	assign out_valid = (state_q == TS_OUT);
	assign out_acc = out_valid && out_ready;
	assign last_word = out_valid && (idx_q == 3'd7);

	// a closed message restarts at byte zero
	assign fill_eff = open_q ? fill_q : 6'd0;
	assign total_eff = open_q ? total_q : 29'd0;

	// length bytes, big-endian, in the last four bytes of the final block
	always_comb begin
		unique case (fill_q[1:0])
			2'd0: len_byte = bits_q[31:24];
			2'd1: len_byte = bits_q[23:16];
			2'd2: len_byte = bits_q[15:8];
			default: len_byte = bits_q[7:0];
		endcase
	end

	// byte packing into the block memory
	always_comb begin
		put_en = 1'b0;
		put_byte = 8'h00;
		if (in_acc) begin
			put_en = 1'b1;
			put_byte = kind ? PAD_MARK : data_byte;
		end else if (state_q == TS_PAD) begin
			put_en = 1'b1;
			put_byte = (!extra_q && fill_q >= LEN_FIELD_START) ? len_byte : 8'h00;
		end
		put.we = put_en && (fill_eff[1:0] == 2'd3);
		put.addr = fill_eff[5:2];
		put.data = {wa_q, put_byte};
		ctl.load_iv = in_acc && !open_q;
		ctl.start = put_en && (fill_eff == BLOCK_LAST_BYTE);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			TS_IDLE: begin
				if (in_acc) begin
					if (fill_eff == BLOCK_LAST_BYTE) state_d = TS_CMP;
					else if (kind) state_d = TS_PAD;
				end
			end
			TS_PAD: begin
				if (fill_q == BLOCK_LAST_BYTE) state_d = TS_CMP;
			end
			TS_CMP: begin
				if (done) begin
					priority if (!fin_q) state_d = TS_IDLE;
					else if (extra_q) state_d = TS_PAD;
					else state_d = TS_OUT;
				end
			end
			TS_OUT: begin
				if (out_acc && idx_q == 3'd7) state_d = TS_IDLE;
			end
			default: state_d = TS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TS_IDLE;
			for (int i = 0; i < IV_WORDS; i++) iv_q[i] <= '0;
			fill_q <= '0;
			total_q <= '0;
			open_q <= 1'b0;
			fin_q <= 1'b0;
			extra_q <= 1'b0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we && !cfg_index[3]) iv_q[cfg_index[2:0]] <= cfg_wdata;
			if (put_en) fill_q <= fill_eff + 6'd1;
			if (in_acc) begin
				open_q <= 1'b1;
				fin_q <= kind;
				extra_q <= kind && (fill_eff >= LONG_TAIL_FILL);
				total_q <= kind ? total_eff : total_eff + 29'd1;
			end
			if (state_q == TS_CMP && done && fin_q) begin
				extra_q <= 1'b0;
				idx_q <= '0;
			end
			if (out_acc) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == 3'd7) begin
					open_q <= 1'b0;
					fin_q <= 1'b0;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (put_en) wa_q <= {wa_q[15:0], put_byte};
		if (in_acc && kind) bits_q <= {total_eff, 3'b000};
	end

	shcv_compress u_compress (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.iv        (iv_q),
		.put       (put),
		.out_sel   (idx_q),
		.done      (done),
		.hash_word (digest_word)
	);

endmodule

>>> design/shcv_ram.sv
module shcv_ram (
	input  logic                clk,
	input  logic                we,
	input  logic [3:0]          waddr,
	input  shcv_pkg::word_t     wdata,
	input  logic [3:0]          raddr,
	output shcv_pkg::word_t     rdata
);
	import shcv_pkg::*;

	word_t mem [16];

	// one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/shcv_compress.sv
module shcv_compress (
	input  logic                clk,
	input  logic                arst_n,
	input  shcv_pkg::cmp_ctl_t  ctl,
	input  shcv_pkg::word_t     iv [8],
	input  shcv_pkg::put_t      put,
	input  logic [2:0]          out_sel,
	output logic                done,
	output shcv_pkg::word_t     hash_word
);
	import shcv_pkg::*;

	cmp_state_t state_q, state_d;
	logic [5:0] rnd_q;
	logic [2:0] ph_q;
	word_t hash_q [8];
	word_t var_q [8];
	word_t w16_q, w15_q, w7_q, w_q, t1_q, t2_q;
	word_t rdata;
	logic [3:0] raddr;
	logic mem_we;
	logic [3:0] mem_waddr;
	word_t mem_wdata;
	logic sched_wr;

	// schedule words overwrite the block in place from round 16 on
	assign sched_wr = (state_q == CS_ROUND) && (ph_q == PH_SUM) && (rnd_q[5:4] != 2'b00);
	assign mem_we = sched_wr || put.we;
	assign mem_waddr = sched_wr ? rnd_q[3:0] : put.addr;
	assign mem_wdata = sched_wr ? w_q : put.data;

	// window taps: r-16, r-15, r-7, r-2 modulo 16
	always_comb begin
		unique case (ph_q)
			PH_RD15: raddr = rnd_q[3:0] + 4'd1;
			PH_RD7:  raddr = rnd_q[3:0] + 4'd9;
			PH_RD2:  raddr = rnd_q[3:0] + 4'd14;
			default: raddr = rnd_q[3:0];
		endcase
	end

	shcv_ram u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		state_d = state_q;
		done = 1'b0;
		unique case (state_q)
			CS_IDLE: begin
				if (ctl.start) state_d = CS_ROUND;
			end
			CS_ROUND: begin
				if (ph_q == PH_UPD && rnd_q == ROUND_LAST) state_d = CS_FINAL;
			end
			CS_FINAL: begin
				done = 1'b1;
				state_d = CS_IDLE;
			end
			default: state_d = CS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			rnd_q <= '0;
			ph_q <= PH_RD16;
		end else begin
			state_q <= state_d;
			if (state_q == CS_ROUND) begin
				if (ph_q == PH_UPD) begin
					ph_q <= PH_RD16;
					rnd_q <= rnd_q + 6'd1;
				end else begin
					ph_q <= ph_q + 3'd1;
				end
			end else begin
				ph_q <= PH_RD16;
				rnd_q <= '0;
			end
		end
	end

	// round datapath
	always_ff @(posedge clk) begin
		if (ctl.load_iv) begin
			hash_q <= iv;
		end
		if (state_q == CS_IDLE && ctl.start) begin
			var_q <= hash_q;
		end
		if (state_q == CS_FINAL) begin
			for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + var_q[i];
		end
		if (state_q == CS_ROUND) begin
			unique case (ph_q)
				PH_RD15: w16_q <= rdata;
				PH_RD7:  w15_q <= rdata;
				PH_RD2:  w7_q <= rdata;
				PH_WORD: begin
					if (rnd_q[5:4] == 2'b00) w_q <= w16_q;
					else w_q <= sml_sig1(rdata) + w7_q + sml_sig0(w15_q) + w16_q;
				end
				PH_SUM: begin
					t1_q <= var_q[7] + big_sig1(var_q[4])
						+ ((var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]))
						+ round_k(rnd_q) + w_q;
					t2_q <= big_sig0(var_q[0]) + ((var_q[0] & var_q[1])
						^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]));
				end
				PH_UPD: begin
					var_q[7] <= var_q[6];
					var_q[6] <= var_q[5];
					var_q[5] <= var_q[4];
					var_q[4] <= var_q[3] + t1_q;
					var_q[3] <= var_q[2];
					var_q[2] <= var_q[1];
					var_q[1] <= var_q[0];
					var_q[0] <= t1_q + t2_q;
				end
				default: ;
			endcase
		end
	end

	assign hash_word = hash_q[out_sel];

endmodule

>>> design/shcv_checker.sv
module shcv_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic last_word
);

	// input and output transactions never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while digest pending");

	// last word only on a valid output
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last_word |-> out_valid)
		else $error("last_word without out_valid");

	// after the last word the output closes
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_word) |=> !out_valid)
		else $error("output stays open after last word");

	// digest words follow back to back until the last one
	a_words_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_word) |=> out_valid)
		else $error("digest sequence broken");

	// an input transaction never yields output in the next cycle
	a_in_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid)
		else $error("output right after input");

endmodule

bind sha256_hash_custom_iv_unit shcv_checker u_shcv_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.last_word (last_word)
);

>>> dv/sha256_digest_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the hash unit, keeps its own model of the
// chaining state and compares every digest word with the model.
module sha256_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] digest_word,
	input  logic        last_word,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	output int          fail_count,
	output int          words_pending
);
	import shcv_pkg::*;

	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} digest_beat_t;

	localparam logic [31:0] KTAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	logic [31:0] iv_shadow [8];
	logic [31:0] chain [8];
	logic [31:0] blk [16];
	logic [5:0]  fill;
	logic [28:0] msg_bytes;
	logic        msg_open;
	digest_beat_t digest_q[$];

	assign words_pending = digest_q.size();

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// one 64-round compression of blk into chain
	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		for (int i = 0; i < 64; i++) begin
			if (i < 16)
				w[i] = blk[i];
			else
				w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
					+ (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
		end
		for (int i = 0; i < 8; i++)
			v[i] = chain[i];
		for (int r = 0; r < 64; r++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[r] + w[r];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] += v[i];
	endtask

	task automatic pack_byte(input logic [7:0] b);
		int sh;
		sh = (3 - fill[1:0]) * 8;
		blk[fill[5:2]] = (blk[fill[5:2]] & ~(32'hff << sh)) | (32'(b) << sh);
		fill = fill + 6'd1;
	endtask

	// advance the model by one accepted input transaction
	task automatic absorb(input logic k, input logic [7:0] b);
		logic [31:0] bits;
		digest_beat_t beat;
		if (!msg_open) begin
			for (int i = 0; i < 8; i++)
				chain[i] = iv_shadow[i];
			fill = '0;
			msg_bytes = '0;
			msg_open = 1'b1;
		end
		if (!k) begin
			pack_byte(b);
			msg_bytes = msg_bytes + 29'd1;
			if (fill == 6'd0)
				compress_block();
			return;
		end
		bits = {msg_bytes, 3'b000};
		pack_byte(PAD_MARK);
		if (fill > LONG_TAIL_FILL || fill == 6'd0) begin
			while (fill != 6'd0)
				pack_byte(8'h00);
			compress_block();
		end
		while (fill < LONG_TAIL_FILL)
			pack_byte(8'h00);
		blk[14] = '0;
		blk[15] = bits;
		fill = '0;
		compress_block();
		for (int i = 0; i < 8; i++) begin
			beat.word = chain[i];
			beat.last = (i == 7);
			digest_q.push_back(beat);
		end
		msg_open = 1'b0;
		msg_bytes = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		digest_beat_t exp_beat;
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				iv_shadow[i] = '0;
				chain[i] = '0;
			end
			for (int i = 0; i < 16; i++)
				blk[i] = '0;
			fill = '0;
			msg_bytes = '0;
			msg_open = 1'b0;
			digest_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_we && cfg_index < IV_WORDS)
				iv_shadow[cfg_index[2:0]] = cfg_wdata;
			if (in_valid && in_ready)
				absorb(kind, data_byte);
			// output transaction against oldest expectation
			if (out_valid && out_ready) begin
				if (digest_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected digest transaction: exp none act %h/%b",
						$time, digest_word, last_word);
				end else begin
					exp_beat = digest_q.pop_front();
					if (digest_word !== exp_beat.word) begin
						fail_count++;
						$display("%0t: digest_word exp %h act %h", $time, exp_beat.word,
							digest_word);
					end
					if (last_word !== exp_beat.last) begin
						fail_count++;
						$display("%0t: last_word exp %b act %b", $time, exp_beat.last,
							last_word);
					end
				end
			end
		end
	end
endmodule

>>> dv/sha256_hash_custom_iv_unit_tb.sv
`timescale 1ns / 1ps

module sha256_hash_custom_iv_unit_tb;
	import shcv_pkg::*;

	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        kind;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] digest_word;
	logic        last_word;
	logic        cfg_we;
	logic [3:0]  cfg_index;
	logic [31:0] cfg_wdata;
	int          fail_count;
	int          words_pending;
	int          burst_left;

	sha256_hash_custom_iv_unit uut (.*);

	sha256_digest_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver stall pattern: calm stretches and stormy stretches
	initial begin
		int mode;
		out_ready = 1'b0;
		mode = 0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 63) == 0)
				mode = $urandom_range(0, 2);
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				default: out_ready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	// one input transaction; gaps between random-length bursts
	task automatic send(input logic k, input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		kind <= k;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	// valid drops after the finish; the unit is busy padding and compressing anyway
	task automatic send_msg(input int len, input logic rnd);
		for (int i = 0; i < len; i++)
			send(KIND_BYTE, rnd ? 8'($urandom) : ((i % 2) ? 8'hff : 8'h00));
		send(KIND_FINISH, 8'($urandom));
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drain();
		while (words_pending != 0)
			@(posedge clk);
		repeat (1000) @(posedge clk);
	endtask

	task automatic write_iv(input logic [3:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic load_ivs(input int style);
		for (int i = 0; i < 8; i++)
			case (style)
				0: write_iv(4'(i), 32'h0);
				1: write_iv(4'(i), 32'hffffffff);
				default: write_iv(4'(i), $urandom);
			endcase
		cfg_we <= 1'b0;
	endtask

	initial begin
		int len;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_BYTE;
		data_byte = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		burst_left = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset iv, empty message, tail lengths around the split
		send_msg(0, 1'b0);
		wait_drain();
		load_ivs(1);
		send_msg(0, 1'b0);
		send_msg(3, 1'b0);
		wait_drain();
		// out-of-range index must be ignored
		write_iv(4'd8, 32'hdeadbeef);
		write_iv(4'd15, 32'h12345678);
		load_ivs(2);
		send_msg(55, 1'b1);
		send_msg(56, 1'b1);
		wait_drain();
		load_ivs(0);
		send_msg(63, 1'b0);
		send_msg(64, 1'b1);
		wait_drain();

		// random short messages under a few iv settings
		for (int m = 0; m < 5; m++) begin
			if (m % 3 == 0) begin
				wait_drain();
				load_ivs(m == 3 ? 1 : 2);
			end
			len = $urandom_range(0, 10);
			send_msg(len, 1'b1);
		end
		wait_drain();

		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
